### rtl/sha512_hash_engine_top_defines.svh
// Assertion macros used by the SHA-512 controller.
`ifndef SHA512_HASH_ENGINE_TOP_DEFINES_SVH
`define SHA512_HASH_ENGINE_TOP_DEFINES_SVH
// Checks that an implication holds at every clock edge outside reset.
`define SHA_ASSERT_IMPL(label, clk, rst, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) else $error(msg);
// Checks that a condition holds in the cycle after a trigger.
`define SHA_ASSERT_NEXT(label, clk, rst, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);
`endif

### rtl/sha512_pkg.sv
// Package with types, constants and round functions for the SHA-512 engine.
package sha512_pkg;

  localparam int WordW = 64;
  localparam int RoundW = 7;
  localparam int NumRounds = 80;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ROUND,
    ST_FOLD,
    ST_PAD,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic       load_word;
    logic       final_word;
    logic [3:0] byte_count;
    logic       start_block;
    logic       round_step;
    logic       fold;
    logic       pad;
    logic       pad_len;
    logic       restart;
    logic       emit_step;
  } cmd_t;

  typedef struct packed {
    logic       block_full;
    logic       need_extra;
    logic       rounds_done;
    logic       emit_done;
    logic [6:0] bytes_filled;
  } status_t;

  function automatic logic [63:0] rotr(input logic [63:0] x, input int n);
    rotr = (x >> n) | (x << (64 - n));
  endfunction

  function automatic logic [63:0] round_const(input logic [RoundW-1:0] i);
    logic [63:0] k [0:79];
    k = '{
      64'h428a2f98d728ae22, 64'h7137449123ef65cd, 64'hb5c0fbcfec4d3b2f, 64'he9b5dba58189dbbc,
      64'h3956c25bf348b538, 64'h59f111f1b605d019, 64'h923f82a4af194f9b, 64'hab1c5ed5da6d8118,
      64'hd807aa98a3030242, 64'h12835b0145706fbe, 64'h243185be4ee4b28c, 64'h550c7dc3d5ffb4e2,
      64'h72be5d74f27b896f, 64'h80deb1fe3b1696b1, 64'h9bdc06a725c71235, 64'hc19bf174cf692694,
      64'he49b69c19ef14ad2, 64'hefbe4786384f25e3, 64'h0fc19dc68b8cd5b5, 64'h240ca1cc77ac9c65,
      64'h2de92c6f592b0275, 64'h4a7484aa6ea6e483, 64'h5cb0a9dcbd41fbd4, 64'h76f988da831153b5,
      64'h983e5152ee66dfab, 64'ha831c66d2db43210, 64'hb00327c898fb213f, 64'hbf597fc7beef0ee4,
      64'hc6e00bf33da88fc2, 64'hd5a79147930aa725, 64'h06ca6351e003826f, 64'h142929670a0e6e70,
      64'h27b70a8546d22ffc, 64'h2e1b21385c26c926, 64'h4d2c6dfc5ac42aed, 64'h53380d139d95b3df,
      64'h650a73548baf63de, 64'h766a0abb3c77b2a8, 64'h81c2c92e47edaee6, 64'h92722c851482353b,
      64'ha2bfe8a14cf10364, 64'ha81a664bbc423001, 64'hc24b8b70d0f89791, 64'hc76c51a30654be30,
      64'hd192e819d6ef5218, 64'hd69906245565a910, 64'hf40e35855771202a, 64'h106aa07032bbd1b8,
      64'h19a4c116b8d2d0c8, 64'h1e376c085141ab53, 64'h2748774cdf8eeb99, 64'h34b0bcb5e19b48a8,
      64'h391c0cb3c5c95a63, 64'h4ed8aa4ae3418acb, 64'h5b9cca4f7763e373, 64'h682e6ff3d6b2b8a3,
      64'h748f82ee5defb2fc, 64'h78a5636f43172f60, 64'h84c87814a1f0ab72, 64'h8cc702081a6439ec,
      64'h90befffa23631e28, 64'ha4506cebde82bde9, 64'hbef9a3f7b2c67915, 64'hc67178f2e372532b,
      64'hca273eceea26619c, 64'hd186b8c721c0c207, 64'heada7dd6cde0eb1e, 64'hf57d4f7fee6ed178,
      64'h06f067aa72176fba, 64'h0a637dc5a2c898a6, 64'h113f9804bef90dae, 64'h1b710b35131c471b,
      64'h28db77f523047d84, 64'h32caab7b40c72493, 64'h3c9ebe0a15c9bebc, 64'h431d67c49c100d4c,
      64'h4cc5d4becb3e42b6, 64'h597f299cfc657e2a, 64'h5fcb6fab3ad6faec, 64'h6c44198c4a475817};
    round_const = k[i];
  endfunction

  function automatic logic [63:0] init_value(input logic mode, input logic [2:0] i);
    logic [63:0] v [0:15];
    v = '{
      64'h6a09e667f3bcc908, 64'hbb67ae8584caa73b, 64'h3c6ef372fe94f82b, 64'ha54ff53a5f1d36f1,
      64'h510e527fade682d1, 64'h9b05688c2b3e6c1f, 64'h1f83d9abfb41bd6b, 64'h5be0cd19137e2179,
      64'hcbbb9d5dc1059ed8, 64'h629a292a367cd507, 64'h9159015a3070dd17, 64'h152fecd8f70e5939,
      64'h67332667ffc00b31, 64'h8eb44a8768581511, 64'hdb0c2e0d64f98fa7, 64'h47b5481dbefa4fa4};
    init_value = v[{mode, i}];
  endfunction

endpackage

### rtl/sha512_hash_engine_top.sv
// Top level of the SHA-512 / SHA-384 hash engine.
// Channel   Dir  tdata                              tuser
// s_axis    in   [63:0] message_word, [67:64] count  final_word in tlast
// m_axis    out  [63:0] digest_word                  [2:0] word_index, tlast last word
// The word that fills a 128-byte block adds 80 rounds and a fold; input is not
// ready again until these are done, so a new word waits while a block is hashed.
// A final word adds one or two padding blocks, each hashed, then 6 or 8 transfers.
// The digest is shown one word per transfer; the output stalls hold it in place.
// Reset is synchronous and loads the SHA-512 initial value.
module sha512_hash_engine_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [71:0] s_axis_tdata,   // message_word [63:0], byte_count [67:64]
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata,   // digest_word [63:0]
  output logic [2:0]  m_axis_tuser,   // word_index [2:0]
  output logic        m_axis_tlast,
  input  logic        cfg_we,
  input  logic        cfg_data
);

  sha512_pkg::cmd_t    cmd;
  sha512_pkg::status_t status;

  sha512_ctrl u_ctrl (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .in_byte_count(s_axis_tdata[67:64]), .in_final(s_axis_tlast),
    .m_axis_tready(m_axis_tready), .m_axis_tvalid(m_axis_tvalid),
    .cfg_we(cfg_we), .status(status), .cmd(cmd)
  );

  logic emit_state;
  assign emit_state = cmd.emit_step || (!cmd.load_word && !cmd.round_step && !cmd.fold
                      && !cmd.pad && !s_axis_tready && !cfg_we);

  sha512_datapath u_dp (
    .clk(clk), .rst(rst),
    .in_word(s_axis_tdata[63:0]), .cfg_data(cfg_data),
    .m_axis_tready(m_axis_tready), .cmd(cmd), .in_emit_state(emit_state),
    .status(status), .m_axis_tvalid(m_axis_tvalid),
    .out_word(m_axis_tdata), .out_index(m_axis_tuser), .out_last(m_axis_tlast)
  );

  logic unused_hi;
  assign unused_hi = ^s_axis_tdata[71:68];

endmodule

### rtl/sha512_ctrl.sv
// Controller state machine that sequences loading, rounds, padding and output.
`include "sha512_hash_engine_top_defines.svh"
module sha512_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [3:0]            in_byte_count,
  input  logic                  in_final,
  input  logic                  m_axis_tready,
  input  logic                  m_axis_tvalid,
  input  logic                  cfg_we,
  input  sha512_pkg::status_t   status,
  output sha512_pkg::cmd_t      cmd
);

  sha512_pkg::state_t state, state_next;
  logic fin, fin_next;
  logic len_pending, len_pending_next;
  logic len_only, len_only_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sha512_pkg::ST_IDLE;
      fin <= 1'b0;
      len_pending <= 1'b0;
      len_only <= 1'b0;
    end else begin
      state <= state_next;
      fin <= fin_next;
      len_pending <= len_pending_next;
      len_only <= len_only_next;
    end
  end

  logic take;
  logic [6:0] filled_after;
  logic [3:0] n_clamped;
  assign take = s_axis_tvalid && s_axis_tready;
  assign n_clamped = (in_byte_count > 4'd8) ? 4'd8 : in_byte_count;
  assign filled_after = status.bytes_filled + (in_final ? {3'd0, n_clamped} : 7'd8);

  always_comb begin
    state_next = state;
    fin_next = fin;
    len_pending_next = len_pending;
    len_only_next = len_only;
    unique case (state)
      sha512_pkg::ST_IDLE: begin
        if (cfg_we) begin
          state_next = sha512_pkg::ST_IDLE;
        end else if (take) begin
          fin_next = in_final;
          if ({1'b0, status.bytes_filled} + {4'd0, (in_final ? n_clamped : 4'd8)} >= 8'd128) begin
            state_next = sha512_pkg::ST_ROUND;
          end else if (in_final) begin
            state_next = sha512_pkg::ST_PAD;
          end
        end
      end
      sha512_pkg::ST_ROUND: begin
        if (status.rounds_done) begin
          state_next = sha512_pkg::ST_FOLD;
        end
      end
      sha512_pkg::ST_FOLD: begin
        if (!fin) begin
          state_next = sha512_pkg::ST_IDLE;
        end else if (len_pending) begin
          state_next = sha512_pkg::ST_PAD;
        end else begin
          state_next = sha512_pkg::ST_EMIT;
        end
      end
      sha512_pkg::ST_PAD: begin
        state_next = sha512_pkg::ST_ROUND;
        len_pending_next = status.need_extra && !len_only;
        len_only_next = status.need_extra && !len_only;
      end
      sha512_pkg::ST_EMIT: begin
        if (m_axis_tvalid && m_axis_tready && status.emit_done) begin
          state_next = sha512_pkg::ST_IDLE;
          fin_next = 1'b0;
        end
      end
      default: state_next = sha512_pkg::ST_IDLE;
    endcase
    if (state == sha512_pkg::ST_IDLE && take && in_final) begin
      len_pending_next = 1'b1;
    end
  end

  always_comb begin
    cmd = '0;
    s_axis_tready = (state == sha512_pkg::ST_IDLE) && !cfg_we;
    cmd.byte_count = in_byte_count;
    cmd.final_word = in_final;
    cmd.restart = cfg_we;
    unique case (state)
      sha512_pkg::ST_IDLE: begin
        cmd.load_word = take;
        cmd.start_block = take && (filled_after == 7'd0 || filled_after[6:0] < status.bytes_filled
                          || ({1'b0, status.bytes_filled} + {4'd0, n_clamped} >= 8'd128));
      end
      sha512_pkg::ST_ROUND: cmd.round_step = 1'b1;
      sha512_pkg::ST_FOLD:  cmd.fold = 1'b1;
      sha512_pkg::ST_PAD: begin
        cmd.pad = 1'b1;
        cmd.pad_len = len_only;
        cmd.start_block = 1'b1;
      end
      sha512_pkg::ST_EMIT: begin
        cmd.emit_step = m_axis_tvalid && m_axis_tready;
        cmd.restart = m_axis_tvalid && m_axis_tready && status.emit_done;
      end
      default: cmd = '0;
    endcase
  end

  `SHA_ASSERT_IMPL(a_ready_idle, clk, rst, s_axis_tready, state == sha512_pkg::ST_IDLE,
                   "input ready outside idle")
  `SHA_ASSERT_IMPL(a_emit_only, clk, rst, m_axis_tvalid, state == sha512_pkg::ST_EMIT,
                   "output valid outside emit")
  `SHA_ASSERT_NEXT(a_round_to_fold, clk, rst,
                   state == sha512_pkg::ST_ROUND && status.rounds_done,
                   state == sha512_pkg::ST_FOLD, "rounds did not fold")

endmodule

### rtl/sha512_datapath.sv
// Datapath with buffer, round logic, chaining value, bit count and output.
module sha512_datapath (
  input  logic                clk,
  input  logic                rst,
  input  logic [63:0]         in_word,
  input  logic                cfg_data,
  input  logic                m_axis_tready,
  input  sha512_pkg::cmd_t    cmd,
  input  logic                in_emit_state,
  output sha512_pkg::status_t status,
  output logic                m_axis_tvalid,
  output logic [63:0]         out_word,
  output logic [2:0]          out_index,
  output logic                out_last
);

  logic        mode;
  logic [63:0] cv [0:7];
  logic [63:0] v  [0:7];
  logic [63:0] w  [0:15];
  logic [6:0]  filled;
  logic [63:0] len_lo, len_hi;
  logic [6:0]  rnd;
  logic [2:0]  emit_idx;

  logic [3:0]  n_cl;
  logic [63:0] masked;
  logic [6:0]  add_bytes;
  logic [7:0]  sum_fill;
  logic [63:0] wnew, w_cur, t1, t2, s0, s1, x2, x15;
  logic [63:0] add_bits, len_lo_next;
  logic [3:0]  wi;
  logic [2:0]  bi;
  logic [63:0] head_mask;
  logic        len_fits;

  assign n_cl = (cmd.byte_count > 4'd8) ? 4'd8 : cmd.byte_count;
  assign add_bytes = cmd.final_word ? {3'd0, n_cl} : 7'd8;
  assign sum_fill = {1'b0, filled} + {1'b0, add_bytes};
  assign masked = (!cmd.final_word || n_cl == 4'd8) ? in_word :
                  (n_cl == 4'd0) ? 64'd0 : (in_word & ~(64'hffffffffffffffff >> (8 * n_cl)));
  assign add_bits = {54'd0, add_bytes, 3'd0};
  assign len_lo_next = len_lo + add_bits;

  assign wi = filled[6:3];
  assign bi = filled[2:0];
  assign head_mask = (bi == 3'd0) ? 64'd0 : ~(64'hffffffffffffffff >> (8 * bi));
  assign len_fits = cmd.pad_len || !status.need_extra;

  assign x2 = w[4'(rnd - 7'd2)];
  assign x15 = w[4'(rnd - 7'd15)];
  assign s1 = sha512_pkg::rotr(x2, 19) ^ sha512_pkg::rotr(x2, 61) ^ (x2 >> 6);
  assign s0 = sha512_pkg::rotr(x15, 1) ^ sha512_pkg::rotr(x15, 8) ^ (x15 >> 7);
  assign wnew = s1 + w[4'(rnd - 7'd7)] + s0 + w[rnd[3:0]];
  assign w_cur = (rnd >= 7'd16) ? wnew : w[rnd[3:0]];
  assign t1 = v[7] + (sha512_pkg::rotr(v[4], 14) ^ sha512_pkg::rotr(v[4], 18)
              ^ sha512_pkg::rotr(v[4], 41)) + ((v[4] & v[5]) ^ (~v[4] & v[6]))
              + sha512_pkg::round_const(rnd) + w_cur;
  assign t2 = (sha512_pkg::rotr(v[0], 28) ^ sha512_pkg::rotr(v[0], 34)
              ^ sha512_pkg::rotr(v[0], 39)) + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= 1'b0;
      filled <= '0;
      len_lo <= '0;
      len_hi <= '0;
      rnd <= '0;
      emit_idx <= '0;
      for (int i = 0; i < 8; i++) cv[i] <= sha512_pkg::init_value(1'b0, 3'(i));
    end else begin
      if (cmd.load_word) begin
        w[wi] <= masked;
        len_lo <= len_lo_next;
        if (len_lo_next < add_bits) len_hi <= len_hi + 64'd1;
        filled <= sum_fill[6:0];
      end
      if (cmd.start_block) begin
        rnd <= '0;
        for (int i = 0; i < 8; i++) v[i] <= cv[i];
      end
      if (cmd.pad) begin
        for (int k = 0; k < 16; k++) begin
          if (!cmd.pad_len && 4'(k) == wi) w[k] <= (w[k] & head_mask) | (64'h80 << (8 * (7 - bi)));
          else if (k == 14 && len_fits) w[k] <= len_hi;
          else if (k == 15 && len_fits) w[k] <= len_lo;
          else if (cmd.pad_len || 4'(k) > wi) w[k] <= '0;
        end
        if (!cmd.pad_len && status.need_extra) filled <= '0;
      end
      if (cmd.round_step) begin
        w[rnd[3:0]] <= w_cur;
        v[7] <= v[6]; v[6] <= v[5]; v[5] <= v[4]; v[4] <= v[3] + t1;
        v[3] <= v[2]; v[2] <= v[1]; v[1] <= v[0]; v[0] <= t1 + t2;
        rnd <= rnd + 7'd1;
      end
      if (cmd.fold) begin
        for (int i = 0; i < 8; i++) cv[i] <= cv[i] + v[i];
        if (!cmd.final_word) filled <= filled;
      end
      if (cmd.emit_step && !cmd.restart) emit_idx <= emit_idx + 3'd1;
      if (cmd.restart) begin
        if (in_emit_state) begin
          for (int i = 0; i < 8; i++) cv[i] <= sha512_pkg::init_value(mode, 3'(i));
        end else begin
          mode <= cfg_data;
          for (int i = 0; i < 8; i++) cv[i] <= sha512_pkg::init_value(cfg_data, 3'(i));
        end
        filled <= '0;
        len_lo <= '0;
        len_hi <= '0;
        emit_idx <= '0;
      end
    end
  end

  assign status.bytes_filled = filled;
  assign status.block_full = (filled == 7'd0);
  assign status.need_extra = filled >= 7'd112;
  assign status.rounds_done = (rnd == 7'(sha512_pkg::NumRounds - 1));
  assign status.emit_done = (emit_idx == (mode ? 3'd5 : 3'd7));

  assign m_axis_tvalid = in_emit_state;
  assign out_word = cv[emit_idx];
  assign out_index = emit_idx;
  assign out_last = status.emit_done;

  logic unused;
  assign unused = m_axis_tready;

endmodule
